// ===== design/stepper_ramp_pulse_generator_macros.svh =====
// ----------------------------------------------------------------------------
// stepper ramp pulse generator assertion macros
// implication and invariant checks, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef STEPPER_RAMP_PULSE_GENERATOR_MACROS_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define SRPG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srpg same-cycle check failed");

// antecedent implies consequent in the next cycle
`define SRPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srpg next-cycle check failed");

`else

`define SRPG_ASSERT_SAME(label, clk, rst, ante, cons)
`define SRPG_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/srpg_pkg.sv =====
// ----------------------------------------------------------------------------
// srpg_pkg
// shared constants, register indexes and types of the stepper ramp generator
// ----------------------------------------------------------------------------
package srpg_pkg;

   localparam int COUNT_BITS_DEFAULT    = 24;
   localparam int FRACTION_BITS_DEFAULT = 8;

   localparam int DELAY_BITS     = 32;
   localparam int STEP_BITS      = 24;
   localparam int RAMP_BITS      = 24;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_HALF_PERIOD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_HALF_PERIOD = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELAY_STEP      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAMP_STEPS      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONSTANT_SPEED  = 3'd4;

   localparam logic OP_MOVE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [DELAY_BITS-1:0] MIN_HALF_PERIOD_RESET = 32'd256000;
   localparam logic [DELAY_BITS-1:0] MAX_HALF_PERIOD_RESET = 32'd25600000;
   localparam logic [DELAY_BITS-1:0] DELAY_STEP_RESET      = 32'd256;
   localparam logic [RAMP_BITS-1:0]  RAMP_STEPS_RESET      = 24'd99000;
   localparam logic                  CONSTANT_SPEED_RESET  = 1'b0;

   typedef struct packed {
      logic [DELAY_BITS-1:0] min_half_period;
      logic [DELAY_BITS-1:0] max_half_period;
      logic [DELAY_BITS-1:0] delay_step;
      logic [RAMP_BITS-1:0]  ramp_steps;
      logic                  constant_speed;
   } srpg_cfg_type;

endpackage

// ===== design/srpg_delay_adjust.sv =====
// ----------------------------------------------------------------------------
// srpg_delay_adjust
// half period update at the end of each step: accelerate, clamp, decelerate
// ----------------------------------------------------------------------------
module srpg_delay_adjust #(
   parameter int COUNT_BITS = srpg_pkg::COUNT_BITS_DEFAULT
) (
   input  srpg_pkg::srpg_cfg_type            cfg,
   input  logic [srpg_pkg::DELAY_BITS-1:0]   cur_delay,
   input  logic                              flat,
   input  logic [COUNT_BITS-1:0]             step_index,
   input  logic [COUNT_BITS-1:0]             move_length,
   input  logic [COUNT_BITS-2:0]             halfway_point,
   output logic [srpg_pkg::DELAY_BITS-1:0]   next_delay
);
   import srpg_pkg::*;

   localparam int DW = ((COUNT_BITS > RAMP_BITS) ? COUNT_BITS : RAMP_BITS) + 1;

   logic [DW-1:0] idx_w;
   logic [DW-1:0] len_w;
   logic [DW-1:0] half_w;
   logic [DW-1:0] ramp_w;
   logic [DW-1:0] tail_w;
   logic          tail_borrow;
   logic          add_en;
   logic [DELAY_BITS-1:0] d_acc;
   logic [DELAY_BITS-1:0] d_clamp;
   logic [DELAY_BITS:0]   d_sum;
   logic [DELAY_BITS-1:0] d_add;

   assign idx_w       = DW'(step_index);
   assign len_w       = DW'(move_length);
   assign half_w      = DW'(halfway_point);
   assign ramp_w      = DW'(cfg.ramp_steps);
   assign tail_borrow = len_w < ramp_w;
   assign tail_w      = len_w - ramp_w;

   always_comb begin
      // acceleration phase
      if ((cur_delay > cfg.min_half_period) && (idx_w < half_w)) begin
         d_acc = (cur_delay > cfg.delay_step) ? (cur_delay - cfg.delay_step) : '0;
      end else begin
         d_acc = cur_delay;
      end
      d_clamp = (d_acc < cfg.min_half_period) ? cfg.min_half_period : d_acc;

      // deceleration phase
      if (flat) begin
         add_en = !tail_borrow && (idx_w > tail_w);
      end else begin
         add_en = idx_w > half_w;
      end
      d_sum = {1'b0, d_clamp} + {1'b0, cfg.delay_step};
      if (add_en) begin
         d_add = d_sum[DELAY_BITS] ? '1 : d_sum[DELAY_BITS-1:0];
      end else begin
         d_add = d_clamp;
      end

      if (!flat && (d_add > cfg.max_half_period)) begin
         next_delay = cfg.max_half_period;
      end else begin
         next_delay = d_add;
      end
   end

endmodule

// ===== design/stepper_ramp_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator: registered result, valid in the cycle after a request is accepted
// throughput 1 request per cycle unless stalled, one result register with stall backpressure
// synchronous active-high reset clears move state and result valid, config to defaults
// ----------------------------------------------------------------------------
`include "stepper_ramp_pulse_generator_macros.svh"

module stepper_ramp_pulse_generator #(
   parameter int COUNT_BITS    = srpg_pkg::COUNT_BITS_DEFAULT,
   parameter int FRACTION_BITS = srpg_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_op,
   input  logic signed [srpg_pkg::STEP_BITS-1:0] req_step_count,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_step_level,
   output logic                                  rsp_dir_level,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_move_done,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [srpg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [srpg_pkg::DELAY_BITS-1:0]       csr_data
);
   import srpg_pkg::*;

   localparam int MW = (COUNT_BITS > STEP_BITS) ? COUNT_BITS : STEP_BITS;
   localparam int FW = (COUNT_BITS > STEP_BITS + 1) ? COUNT_BITS : STEP_BITS + 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
   localparam logic [MW-1:0]         COUNT_MAX_M = MW'(COUNT_MAX);
   localparam logic [DELAY_BITS-1:0] COUNT_MAX_D = DELAY_BITS'(COUNT_MAX);

   srpg_cfg_type cfg_ff;

   logic [COUNT_BITS-1:0] step_index_ff, step_index_in;
   logic [COUNT_BITS-1:0] move_length_ff, move_length_in;
   logic [COUNT_BITS-2:0] halfway_ff, halfway_in;
   logic [DELAY_BITS-1:0] delay_ff, delay_in;
   logic [COUNT_BITS-1:0] wait_ff, wait_in;
   logic                  phase_ff, phase_in;
   logic                  moving_ff, moving_in;
   logic                  dir_ff, dir_in;
   logic                  flat_ff, flat_in;
   logic                  done_in;

   logic                  rsp_valid_ff;
   logic                  rsp_step_level_ff;
   logic                  rsp_dir_level_ff;
   logic                  rsp_busy_res_ff;
   logic                  rsp_move_done_ff;

   logic                  accept;
   logic                  neg;
   logic [STEP_BITS-1:0]  raw;
   logic [STEP_BITS-1:0]  mag_raw;
   logic [MW-1:0]         mag_w;
   logic [COUNT_BITS-1:0] mag;
   logic                  flat_cmd;
   logic [COUNT_BITS-1:0] wait_inc;
   logic [DELAY_BITS-1:0] ticks_raw;
   logic [DELAY_BITS-1:0] ticks;
   logic                  half_end;
   logic [DELAY_BITS-1:0] adj_delay;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_half_period <= MIN_HALF_PERIOD_RESET;
         cfg_ff.max_half_period <= MAX_HALF_PERIOD_RESET;
         cfg_ff.delay_step      <= DELAY_STEP_RESET;
         cfg_ff.ramp_steps      <= RAMP_STEPS_RESET;
         cfg_ff.constant_speed  <= CONSTANT_SPEED_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_HALF_PERIOD: cfg_ff.min_half_period <= csr_data;
            CSR_MAX_HALF_PERIOD: cfg_ff.max_half_period <= csr_data;
            CSR_DELAY_STEP:      cfg_ff.delay_step      <= csr_data;
            CSR_RAMP_STEPS:      cfg_ff.ramp_steps      <= csr_data[RAMP_BITS-1:0];
            CSR_CONSTANT_SPEED:  cfg_ff.constant_speed  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // move command decode
   assign raw      = req_step_count;
   assign neg      = raw[STEP_BITS-1];
   assign mag_raw  = neg ? (~raw + STEP_BITS'(1)) : raw;
   assign mag_w    = MW'(mag_raw);
   assign mag      = (mag_w > COUNT_MAX_M) ? COUNT_MAX : COUNT_BITS'(mag_w);
   assign flat_cmd = FW'(mag) > FW'({cfg_ff.ramp_steps, 1'b0});

   // tick timing
   assign wait_inc  = (wait_ff != COUNT_MAX) ? (wait_ff + COUNT_BITS'(1)) : wait_ff;
   assign ticks_raw = delay_ff >> FRACTION_BITS;
   always_comb begin
      if (ticks_raw == '0) begin
         ticks = DELAY_BITS'(1);
      end else if (ticks_raw > COUNT_MAX_D) begin
         ticks = COUNT_MAX_D;
      end else begin
         ticks = ticks_raw;
      end
   end
   assign half_end = DELAY_BITS'(wait_inc) >= ticks;

   srpg_delay_adjust #(
      .COUNT_BITS (COUNT_BITS)
   ) u_adjust (
      .cfg           (cfg_ff),
      .cur_delay     (delay_ff),
      .flat          (flat_ff),
      .step_index    (step_index_ff),
      .move_length   (move_length_ff),
      .halfway_point (halfway_ff),
      .next_delay    (adj_delay)
   );

   always_comb begin
      step_index_in  = step_index_ff;
      move_length_in = move_length_ff;
      halfway_in     = halfway_ff;
      delay_in       = delay_ff;
      wait_in        = wait_ff;
      phase_in       = phase_ff;
      moving_in      = moving_ff;
      dir_in         = dir_ff;
      flat_in        = flat_ff;
      done_in        = 1'b0;
      if (req_op == OP_MOVE) begin
         dir_in         = !neg;
         move_length_in = mag;
         halfway_in     = mag[COUNT_BITS-1:1];
         flat_in        = flat_cmd;
         delay_in       = cfg_ff.constant_speed ? cfg_ff.min_half_period
                                                : cfg_ff.max_half_period;
         step_index_in  = COUNT_BITS'(1);
         wait_in        = '0;
         phase_in       = 1'b0;
         moving_in      = mag != '0;
      end else if (moving_ff) begin
         wait_in = wait_inc;
         if (half_end) begin
            wait_in = '0;
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               delay_in = adj_delay;
               if (step_index_ff >= move_length_ff) begin
                  moving_in = 1'b0;
                  done_in   = 1'b1;
               end else begin
                  step_index_in = step_index_ff + COUNT_BITS'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_index_ff  <= '0;
         move_length_ff <= '0;
         halfway_ff     <= '0;
         delay_ff       <= '0;
         wait_ff        <= '0;
         phase_ff       <= 1'b0;
         moving_ff      <= 1'b0;
         dir_ff         <= 1'b0;
         flat_ff        <= 1'b0;
      end else if (accept) begin
         step_index_ff  <= step_index_in;
         move_length_ff <= move_length_in;
         halfway_ff     <= halfway_in;
         delay_ff       <= delay_in;
         wait_ff        <= wait_in;
         phase_ff       <= phase_in;
         moving_ff      <= moving_in;
         dir_ff         <= dir_in;
         flat_ff        <= flat_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_step_level_ff <= phase_in;
         rsp_dir_level_ff  <= dir_in;
         rsp_busy_res_ff   <= moving_in;
         rsp_move_done_ff  <= done_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_step_level = rsp_step_level_ff;
   assign rsp_dir_level  = rsp_dir_level_ff;
   assign rsp_busy_res   = rsp_busy_res_ff;
   assign rsp_move_done  = rsp_move_done_ff;

   `SRPG_ASSERT_SAME(a_done_not_busy, clock, reset, rsp_valid_ff && rsp_move_done_ff, !rsp_busy_res_ff)
   `SRPG_ASSERT_SAME(a_index_in_range, clock, reset, moving_ff, step_index_ff <= move_length_ff)
   `SRPG_ASSERT_NEXT(a_move_starts_low, clock, reset, accept && (req_op == OP_MOVE), !phase_ff && (wait_ff == '0))
   `SRPG_ASSERT_NEXT(a_idle_tick_holds, clock, reset, accept && (req_op == OP_TICK) && !moving_ff, $stable(phase_ff) && $stable(delay_ff))

endmodule

// ===== verif/stepper_ramp_pulse_generator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator_test
// feeds move commands and microsecond ticks to the ramp pulse generator and
// checks the step, direction, busy and done levels of every result against a
// cycle-free ramp model or pinned table levels; a directed table opens
// the run, then random register settings and moves, with stalls on both sides
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator_test;
   import srpg_pkg::*;

   localparam int COUNT_BITS    = COUNT_BITS_DEFAULT;
   localparam int FRACTION_BITS = FRACTION_BITS_DEFAULT;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam int QUIET_LIMIT   = 4000;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 170;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic step_level;
      logic dir_level;
      logic busy;
      logic done;
   } pulse_levels_type;

   typedef enum logic {ROW_REQUEST, ROW_REGISTER} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic                      op;
      logic [STEP_BITS-1:0]      count;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [DELAY_BITS-1:0]     data;
      logic                      pinned;
      pulse_levels_type          levels;
   } stim_row_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic                        req_op;
   logic signed [STEP_BITS-1:0] req_step_count;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic                        rsp_step_level;
   logic                        rsp_dir_level;
   logic                        rsp_busy_res;
   logic                        rsp_move_done;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index;
   logic [DELAY_BITS-1:0]       csr_data;

   // fixed expectation traveling with a request from the table
   logic                        pin_use;
   pulse_levels_type            pin_levels;

   bit tx_idling = 1'b1;
   bit rx_idling = 1'b1;
   int hold_requests = 0;
   int holds_done = 0;

   stim_row_type     stim_rows[$];
   pulse_levels_type pending_levels[$];
   int               flaw_count = 0;
   int               result_no = 0;
   int               quiet_cycles = 0;

   // model state
   srpg_cfg_type            motor_cfg;
   logic [COUNT_BITS-1:0]   step_no;
   logic [COUNT_BITS-1:0]   move_len;
   logic [COUNT_BITS-2:0]   midpoint;
   logic [DELAY_BITS-1:0]   half_delay;
   logic [COUNT_BITS-1:0]   wait_ticks;
   logic                    phase_high;
   logic                    in_motion;
   logic                    heading;
   logic                    flat_move;

   stepper_ramp_pulse_generator dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_step_count (req_step_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_step_level (rsp_step_level),
      .rsp_dir_level  (rsp_dir_level),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_move_done  (rsp_move_done),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [DELAY_BITS-1:0] add_clip(input logic [DELAY_BITS-1:0] a,
                                                      input logic [DELAY_BITS-1:0] b);
      logic [DELAY_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[DELAY_BITS] ? '1 : sum[DELAY_BITS-1:0];
   endfunction

   function automatic logic [DELAY_BITS-1:0] sub_clip(input logic [DELAY_BITS-1:0] a,
                                                      input logic [DELAY_BITS-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction

   task automatic advance_motor(input logic op, input logic [STEP_BITS-1:0] count,
                                output pulse_levels_type levels);
      logic [STEP_BITS-1:0]  mag;
      logic [DELAY_BITS-1:0] d;
      logic [DELAY_BITS-1:0] span;
      logic [COUNT_BITS:0]   tail_start;
      logic                  finished;
      finished = 1'b0;
      if (op == OP_MOVE) begin
         heading = ~count[STEP_BITS-1];
         mag = count[STEP_BITS-1] ? ~count + 1'b1 : count;
         move_len = (mag > COUNT_MAX) ? COUNT_MAX : mag;
         midpoint = move_len[COUNT_BITS-1:1];
         flat_move = {1'b0, move_len} > {motor_cfg.ramp_steps, 1'b0};
         half_delay = motor_cfg.constant_speed ? motor_cfg.min_half_period
                                               : motor_cfg.max_half_period;
         step_no = COUNT_BITS'(1);
         wait_ticks = '0;
         phase_high = 1'b0;
         in_motion = (move_len != 0);
      end else if (in_motion) begin
         if (wait_ticks != COUNT_MAX) wait_ticks = wait_ticks + 1'b1;
         span = half_delay >> FRACTION_BITS;
         if (span == 0) span = DELAY_BITS'(1);
         if (span > COUNT_MAX) span = DELAY_BITS'(COUNT_MAX);
         if (wait_ticks >= span) begin
            wait_ticks = '0;
            if (!phase_high) begin
               phase_high = 1'b1;
            end else begin
               phase_high = 1'b0;
               // retime the next step
               d = half_delay;
               if (d > motor_cfg.min_half_period && step_no < midpoint)
                  d = sub_clip(d, motor_cfg.delay_step);
               if (d < motor_cfg.min_half_period) d = motor_cfg.min_half_period;
               if (flat_move) begin
                  tail_start = {1'b0, move_len} - {1'b0, motor_cfg.ramp_steps};
                  if ({1'b0, step_no} > tail_start) d = add_clip(d, motor_cfg.delay_step);
               end else begin
                  if (step_no > midpoint) d = add_clip(d, motor_cfg.delay_step);
                  if (d > motor_cfg.max_half_period) d = motor_cfg.max_half_period;
               end
               half_delay = d;
               if (step_no >= move_len) begin
                  in_motion = 1'b0;
                  finished = 1'b1;
               end else begin
                  step_no = step_no + 1'b1;
               end
            end
         end
      end
      levels = {phase_high, heading, in_motion, finished};
   endtask

   // model update and result check
   always @(posedge clock) begin
      pulse_levels_type want;
      pulse_levels_type got;
      if (reset) begin
         motor_cfg = '{MIN_HALF_PERIOD_RESET, MAX_HALF_PERIOD_RESET, DELAY_STEP_RESET,
                       RAMP_STEPS_RESET, CONSTANT_SPEED_RESET};
         step_no = '0;
         move_len = '0;
         midpoint = '0;
         half_delay = '0;
         wait_ticks = '0;
         phase_high = 1'b0;
         in_motion = 1'b0;
         heading = 1'b0;
         flat_move = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_step_level, rsp_dir_level, rsp_busy_res, rsp_move_done};
            result_no++;
            if (pending_levels.size() == 0) begin
               flaw_count++;
               if (flaw_count <= REPORT_LIMIT)
                  $display("result %0d arrived with no request waiting: %b", result_no, got);
            end else begin
               want = pending_levels.pop_front();
               if (got !== want) begin
                  flaw_count++;
                  if (flaw_count <= REPORT_LIMIT)
                     $display("result %0d expected/actual: step %b/%b dir %b/%b busy %b/%b done %b/%b",
                              result_no, want.step_level, got.step_level,
                              want.dir_level, got.dir_level, want.busy, got.busy,
                              want.done, got.done);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIN_HALF_PERIOD: motor_cfg.min_half_period = csr_data;
               CSR_MAX_HALF_PERIOD: motor_cfg.max_half_period = csr_data;
               CSR_DELAY_STEP:      motor_cfg.delay_step = csr_data;
               CSR_RAMP_STEPS:      motor_cfg.ramp_steps = csr_data[RAMP_BITS-1:0];
               CSR_CONSTANT_SPEED:  motor_cfg.constant_speed = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            advance_motor(req_op, req_step_count, want);
            pending_levels.push_back(pin_use ? pin_levels : want);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("stepper_ramp_pulse_generator_test: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: stall bursts and the long hold-off
   initial begin : receiver
      int run;
      forever begin
         if (holds_done != hold_requests) begin
            holds_done++;
            rsp_stall <= 1'b1;
            run = LONG_HOLD;
         end else if (rx_idling && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            run = $urandom_range(1, 12);
         end else begin
            rsp_stall <= 1'b0;
            run = $urandom_range(1, 20);
         end
         repeat (run) @(posedge clock);
      end
   end

   function automatic void add_request(input logic op, input logic [STEP_BITS-1:0] count,
                                       input logic pinned, input pulse_levels_type levels);
      stim_row_type row;
      row.kind = ROW_REQUEST;
      row.op = op;
      row.count = count;
      row.index = '0;
      row.data = '0;
      row.pinned = pinned;
      row.levels = levels;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_register(input logic [CSR_INDEX_BITS-1:0] index,
                                        input logic [DELAY_BITS-1:0] data);
      stim_row_type row;
      row.kind = ROW_REGISTER;
      row.op = OP_TICK;
      row.count = '0;
      row.index = index;
      row.data = data;
      row.pinned = 1'b0;
      row.levels = '0;
      stim_rows.push_back(row);
   endfunction

   task automatic send_request(input logic op, input logic [STEP_BITS-1:0] count,
                               input logic pinned, input pulse_levels_type levels);
      if (tx_idling && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_step_count <= count;
      pin_use <= pinned;
      pin_levels <= levels;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [DELAY_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_levels.size() != 0);
   endtask

   initial begin : stimulus
      srpg_cfg_type          plan;
      logic [STEP_BITS-1:0]  count;
      logic [DELAY_BITS-1:0] top;
      int                    roll;
      int                    mag;
      int                    span;
      int                    ticks;
      int                    sent;

      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_TICK;
      req_step_count = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      pin_use = 1'b0;
      pin_levels = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // levels are {step, dir, busy, done}
      add_request(OP_TICK, 24'h000000, 1'b1, 4'b0000);
      add_request(OP_MOVE, 24'h800000, 1'b1, 4'b0010);
      add_request(OP_TICK, 24'hFFFFFF, 1'b1, 4'b0010);
      add_request(OP_MOVE, 24'h7FFFFF, 1'b1, 4'b0110);
      add_request(OP_MOVE, 24'h000000, 1'b1, 4'b0100);
      add_request(OP_TICK, 24'h5A5A5A, 1'b1, 4'b0100);
      add_request(OP_MOVE, 24'hFFFFFF, 1'b1, 4'b0010);
      add_request(OP_MOVE, 24'h000001, 1'b1, 4'b0110);
      // one tick halves, saturating speed-down on the last step
      add_register(CSR_MIN_HALF_PERIOD, 32'h0000_0000);
      add_register(CSR_MAX_HALF_PERIOD, 32'd256);
      add_register(CSR_DELAY_STEP, 32'hFFFF_FFFF);
      add_register(CSR_RAMP_STEPS, 32'd1);
      add_register(CSR_CONSTANT_SPEED, 32'd0);
      add_request(OP_MOVE, 24'd3, 1'b1, 4'b0110);
      repeat (6) add_request(OP_TICK, 24'hA5A5A5, 1'b0, '0);
      // minimum above maximum, constant speed start
      add_register(CSR_MIN_HALF_PERIOD, 32'd1024);
      add_register(CSR_MAX_HALF_PERIOD, 32'd512);
      add_register(CSR_RAMP_STEPS, 32'h00FF_FFFF);
      add_register(CSR_CONSTANT_SPEED, 32'd1);
      add_request(OP_MOVE, 24'hFFFFFE, 1'b1, 4'b0010);
      repeat (4) add_request(OP_TICK, 24'h000000, 1'b0, '0);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_REGISTER) begin
            if (i == 0 || stim_rows[i-1].kind == ROW_REQUEST) drain_results();
            write_register(stim_rows[i].index, stim_rows[i].data);
         end else begin
            csr_valid <= 1'b0;
            send_request(stim_rows[i].op, stim_rows[i].count, stim_rows[i].pinned,
                         stim_rows[i].levels);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_results();
         case (p)
            1: plan = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h0, 1'b1};
            5: plan = '{32'hFFFF_FFFF, 32'h0, 32'h0, 24'hFF_FFFF, 1'b0};
            7: plan = '{$urandom_range(0, 512), 32'hFFFF_FFFF, $urandom_range(1, 64),
                        24'hFF_FFFF, 1'b1};
            default: begin
               plan.min_half_period = $urandom_range(0, 768);
               plan.max_half_period = $urandom_range(0, 1536);
               roll = $urandom_range(0, 9);
               plan.delay_step = (roll == 0) ? 32'h0 :
                                 (roll == 1) ? 32'hFFFF_FFFF : $urandom_range(1, 300);
               plan.ramp_steps = RAMP_BITS'($urandom_range(0, 4));
               plan.constant_speed = 1'($urandom_range(0, 1));
            end
         endcase
         write_register(CSR_MIN_HALF_PERIOD, plan.min_half_period);
         write_register(CSR_MAX_HALF_PERIOD, plan.max_half_period);
         write_register(CSR_DELAY_STEP, plan.delay_step);
         write_register(CSR_RAMP_STEPS, {8'h00, plan.ramp_steps});
         write_register(CSR_CONSTANT_SPEED, {31'h0, plan.constant_speed});
         csr_valid <= 1'b0;
         tx_idling = (p < RANDOM_PHASES - 2);
         rx_idling = (p < RANDOM_PHASES - 2);
         if (p == 3) hold_requests++;
         top = (plan.min_half_period > plan.max_half_period) ? plan.min_half_period
                                                             : plan.max_half_period;
         span = ((top >> FRACTION_BITS) > 12) ? 12 : int'(top >> FRACTION_BITS);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
               count = '0;
               ticks = $urandom_range(0, 5);
            end else if (roll < 12) begin
               count = STEP_BITS'($urandom_range(0, 24'hFF_FFFF));
               ticks = $urandom_range(0, 200);
            end else begin
               mag = $urandom_range(1, 10);
               count = STEP_BITS'(mag);
               if ($urandom_range(0, 1)) count = ~count + 1'b1;
               ticks = 2 * mag * (span + 2) + 4;
               if (ticks > 400) ticks = 400;
               // cut some moves short with the next command
               if ($urandom_range(0, 4) == 0) ticks = $urandom_range(0, ticks / 2);
            end
            if (ticks > PHASE_ITEMS - sent - 1) ticks = PHASE_ITEMS - sent - 1;
            send_request(OP_MOVE, count, 1'b0, '0);
            sent++;
            repeat (ticks) begin
               send_request(OP_TICK, STEP_BITS'($urandom_range(0, 24'hFF_FFFF)), 1'b0, '0);
               sent++;
            end
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (flaw_count == 0 && pending_levels.size() == 0) begin
         $display("stepper_ramp_pulse_generator_test: clean");
      end else begin
         $display("stepper_ramp_pulse_generator_test: errors");
      end
      $finish;
   end

endmodule
